>>> hw/rtl/assert_macros.svh
// Assertion macros used by the filter's top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

>>> hw/rtl/upf_pkg.sv
// Types and constants of the UDP source port frame filter.
`default_nettype none

package upf_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int PORT_W  = 16;
    localparam int ETYPE_W = 16;
    localparam int IHL_W   = 4;
    localparam int CFG_A_W = 2;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // Byte positions and lengths inside the frame
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 7'd127;
    localparam logic [COUNT_W-1:0] ETYPE_HI_POS = 7'd12;
    localparam logic [COUNT_W-1:0] ETYPE_LO_POS = 7'd13;
    localparam logic [COUNT_W-1:0] ETH_HDR_LEN  = 7'd14;
    localparam logic [COUNT_W-1:0] PROTO_POS    = 7'd23;
    localparam logic [COUNT_W-1:0] IP_MIN_END   = 7'd34;
    localparam logic [COUNT_W-1:0] UDP_HDR_LEN  = 7'd8;

    localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [BYTE_W-1:0]  PROTO_UDP      = 8'd17;

    localparam logic [PORT_W-1:0] PORT_LOW_RESET  = 16'd5350;
    localparam logic [PORT_W-1:0] PORT_HIGH_RESET = 16'd5357;

    typedef enum logic [2:0] {
        CAUSE_NOT_IPV4     = 3'd0,
        CAUSE_NOT_UDP      = 3'd1,
        CAUSE_PORT_ALLOWED = 3'd2,
        CAUSE_SHORT_ETH    = 3'd3,
        CAUSE_SHORT_IP     = 3'd4,
        CAUSE_SHORT_UDP    = 3'd5,
        CAUSE_PORT_MATCHED = 3'd6
    } t_cause;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_PORT_LOW  = 2'd0,
        CFG_PORT_HIGH = 2'd1
    } t_cfg_idx;

    // Header fields as they stand after the current byte is taken in
    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic [ETYPE_W-1:0] ether_type;
        logic [IHL_W-1:0]   ihl;
        logic [BYTE_W-1:0]  protocol;
        logic [PORT_W-1:0]  src_port;
    } t_frame_info;

    typedef struct packed {
        logic              drop;
        t_cause            cause;
        logic [PORT_W-1:0] source_port;
    } t_verdict;

endpackage

`default_nettype wire

>>> hw/rtl/upf_parse.sv
// Frame header tracker: byte counter and capture of ethertype, ihl, protocol, source port.
`default_nettype none

module upf_parse (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [upf_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                       i_last,
    output upf_pkg::t_frame_info            o_info
);
    import upf_pkg::*;

    logic [COUNT_W-1:0] r_count, n_count;
    logic [ETYPE_W-1:0] r_etype, n_etype;
    logic [IHL_W-1:0]   r_ihl, n_ihl;
    logic [BYTE_W-1:0]  r_proto, n_proto;
    logic [PORT_W-1:0]  r_port, n_port;
    logic               in_range;
    logic [COUNT_W-1:0] port_start;

    // Header field updates for the byte at position r_count
    always_comb begin
        in_range   = (r_count < COUNT_MAX);
        n_count    = r_count;
        n_etype    = r_etype;
        n_ihl      = r_ihl;
        n_proto    = r_proto;
        n_port     = r_port;
        if (in_range) begin
            n_count = r_count + 7'd1;
            if (r_count == ETYPE_HI_POS) begin
                n_etype[15:8] = i_byte;
            end else if (r_count == ETYPE_LO_POS) begin
                n_etype[7:0] = i_byte;
            end
            if (r_count == ETH_HDR_LEN) begin
                n_ihl = i_byte[IHL_W-1:0];
            end
            if (r_count == PROTO_POS) begin
                n_proto = i_byte;
            end
        end
        // UDP header starts 4*ihl bytes after the Ethernet header
        port_start = ETH_HDR_LEN + {1'b0, n_ihl, 2'b00};
        if (in_range && (r_count >= ETH_HDR_LEN)) begin
            if (r_count == port_start) begin
                n_port[15:8] = i_byte;
            end else if (r_count == port_start + 7'd1) begin
                n_port[7:0] = i_byte;
            end
        end
    end

    assign o_info.byte_count = n_count;
    assign o_info.ether_type = n_etype;
    assign o_info.ihl        = n_ihl;
    assign o_info.protocol   = n_proto;
    assign o_info.src_port   = n_port;

    // Frame state; cleared after the last byte of each frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_etype <= '0;
            r_port  <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_count <= '0;
                r_etype <= '0;
                r_port  <= '0;
            end else begin
                r_count <= n_count;
                r_etype <= n_etype;
                r_port  <= n_port;
            end
        end
    end

    // IP header bytes kept across frames, only read once written
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_ihl   <= n_ihl;
            r_proto <= n_proto;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/upf_verdict.sv
// Frame classifier: length, ethertype, protocol and port range checks in order.
`default_nettype none

module upf_verdict (
    input  wire upf_pkg::t_frame_info        i_info,
    input  wire logic [upf_pkg::PORT_W-1:0]  i_port_low,
    input  wire logic [upf_pkg::PORT_W-1:0]  i_port_high,
    output upf_pkg::t_verdict                o_verdict
);
    import upf_pkg::*;

    logic [COUNT_W-1:0] udp_end;
    logic               port_hit;

    always_comb begin
        udp_end  = ETH_HDR_LEN + UDP_HDR_LEN + {1'b0, i_info.ihl, 2'b00};
        port_hit = (i_info.src_port >= i_port_low) && (i_info.src_port <= i_port_high);

        o_verdict.source_port = '0;
        if (i_info.byte_count < ETH_HDR_LEN) begin
            o_verdict.drop  = 1'b1;
            o_verdict.cause = CAUSE_SHORT_ETH;
        end else if (i_info.ether_type != ETHERTYPE_IPV4) begin
            o_verdict.drop  = 1'b0;
            o_verdict.cause = CAUSE_NOT_IPV4;
        end else if (i_info.byte_count < IP_MIN_END) begin
            o_verdict.drop  = 1'b1;
            o_verdict.cause = CAUSE_SHORT_IP;
        end else if (i_info.protocol != PROTO_UDP) begin
            o_verdict.drop  = 1'b0;
            o_verdict.cause = CAUSE_NOT_UDP;
        end else if (i_info.byte_count < udp_end) begin
            o_verdict.drop  = 1'b1;
            o_verdict.cause = CAUSE_SHORT_UDP;
        end else begin
            o_verdict.source_port = i_info.src_port;
            o_verdict.drop        = port_hit;
            o_verdict.cause       = port_hit ? CAUSE_PORT_MATCHED : CAUSE_PORT_ALLOWED;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/udp_source_port_packet_filter_unit.sv
// A frame's verdict goes through one input register, then one result register,
// and is held in the result register until the output stream accepts it.
// Throughput: one byte per cycle; the input only stalls while an unaccepted verdict sits in
// the result register and a byte waits in the input register.
// Bytes without the last flag give no output transfer.
// Reset (synchronous, active low) empties both registers, clears the byte count
// and loads port_low = 5350, port_high = 5357.
`default_nettype none
`include "assert_macros.svh"

module udp_source_port_packet_filter_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Slave stream: frame bytes
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [upf_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // [7:0] frame_byte
    input  wire logic                            i_s_axis_tlast,  // end_of_frame
    // Master stream: verdicts
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic [upf_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,  // [0] drop, [3:1] cause,
                                                                   // [19:4] source_port, rest 0
    // Configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [upf_pkg::CFG_A_W-1:0]     i_cfg_addr,
    input  wire logic [upf_pkg::PORT_W-1:0]      i_cfg_wdata
);
    import upf_pkg::*;

    logic [PORT_W-1:0] r_port_low, r_port_high;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    t_verdict          r_out;

    logic              advance;
    logic              step;
    t_frame_info       info;
    t_verdict          verdict;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_low  <= PORT_LOW_RESET;
            r_port_high <= PORT_HIGH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PORT_LOW:  r_port_low  <= i_cfg_wdata;
                CFG_PORT_HIGH: r_port_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline moves when the result register is free or being drained
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && advance;
    assign o_s_axis_tready = advance || !r_in_valid;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata[BYTE_W-1:0];
            r_in_last <= i_s_axis_tlast;
        end
    end

    upf_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_info  (info)
    );

    upf_verdict u_verdict (
        .i_info      (info),
        .i_port_low  (r_port_low),
        .i_port_high (r_port_high),
        .o_verdict   (verdict)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= verdict;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out.source_port, r_out.cause, r_out.drop};

    // A verdict only follows a last byte in the input register
    `ASSERT_CLK(a_out_from_last, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_in_valid && r_in_last))

    // Drop flag agrees with the cause code
    `ASSERT_CLK(a_drop_matches_cause, i_clk, i_rst_n,
        r_out_valid |-> (r_out.drop == (r_out.cause == CAUSE_SHORT_ETH ||
            r_out.cause == CAUSE_SHORT_IP || r_out.cause == CAUSE_SHORT_UDP ||
            r_out.cause == CAUSE_PORT_MATCHED)))

    // Source port is reported only when the port check was reached
    `ASSERT_NEVER(a_port_without_udp, i_clk, i_rst_n,
        r_out_valid && (r_out.source_port != '0) &&
        r_out.cause != CAUSE_PORT_ALLOWED && r_out.cause != CAUSE_PORT_MATCHED)

    // Input side never stalls while the result register is empty
    `ASSERT_CLK(a_ready_when_empty, i_clk, i_rst_n,
        !r_out_valid |-> o_s_axis_tready)

endmodule

`default_nettype wire

>>> sim/udp_source_port_packet_filter_unit_tb.sv
// Testbench for the UDP source port frame filter: directed and random frame streams checked per verdict.
`timescale 1ns / 1ps

module udp_source_port_packet_filter_unit_tb;
    import upf_pkg::*;

    localparam int VERDICT_LATENCY = 2;
    localparam int STALL_LIMIT     = 1000;
    localparam int NUM_PHASES      = 6;

    // Register indexes that the block ignores
    localparam logic [CFG_A_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_A_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_frame_xfer;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_A_W-1:0]     cfg_addr = '0;
    logic [PORT_W-1:0]      cfg_wdata = '0;

    // Stimulus and expectations
    t_frame_xfer frame_byte_q[$];
    t_verdict    verdict_q[$];
    int          errors = 0;
    int          src_idle_pct = 10;
    int          snk_idle_pct = 10;
    int          src_gap = 0;
    int          snk_gap = 0;
    int          stall_cycles = 0;
    int          phase_bytes;
    int          phase_frames;

    // Filter state as the block should hold it
    logic [PORT_W-1:0]  drop_lo = PORT_LOW_RESET;
    logic [PORT_W-1:0]  drop_hi = PORT_HIGH_RESET;
    logic [COUNT_W-1:0] seen_count = '0;
    logic [ETYPE_W-1:0] seen_etype = '0;
    logic [BYTE_W-1:0]  ip_hdr [0:19] = '{default: '0};
    logic [PORT_W-1:0]  port_cap = '0;

    udp_source_port_packet_filter_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),   // [7:0] frame_byte
        .i_s_axis_tlast  (s_axis_tlast),   // end_of_frame
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),   // [0] drop, [3:1] cause, [19:4] source_port
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Take one accepted frame byte into the filter state; queue a verdict at frame end
    task automatic filter_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [COUNT_W-1:0] pos;
        int                 start;
        int                 udp_end;
        t_verdict           v;
        pos = seen_count;
        if (pos < COUNT_MAX) begin
            if (pos == ETYPE_HI_POS)
                seen_etype[15:8] = b;
            else if (pos == ETYPE_LO_POS)
                seen_etype[7:0] = b;
            if (pos >= ETH_HDR_LEN && pos < IP_MIN_END)
                ip_hdr[pos - ETH_HDR_LEN] = b;
            if (pos >= ETH_HDR_LEN) begin
                start = int'(ETH_HDR_LEN) + 4 * int'(ip_hdr[0][3:0]);
                if (int'(pos) == start)
                    port_cap[15:8] = b;
                else if (int'(pos) == start + 1)
                    port_cap[7:0] = b;
            end
            seen_count = pos + 1'b1;
        end
        if (last) begin
            v.source_port = '0;
            if (seen_count < ETH_HDR_LEN) begin
                v.drop  = 1'b1;
                v.cause = CAUSE_SHORT_ETH;
            end else if (seen_etype != ETHERTYPE_IPV4) begin
                v.drop  = 1'b0;
                v.cause = CAUSE_NOT_IPV4;
            end else if (seen_count < IP_MIN_END) begin
                v.drop  = 1'b1;
                v.cause = CAUSE_SHORT_IP;
            end else if (ip_hdr[PROTO_POS - ETH_HDR_LEN] != PROTO_UDP) begin
                v.drop  = 1'b0;
                v.cause = CAUSE_NOT_UDP;
            end else begin
                udp_end = int'(ETH_HDR_LEN) + 4 * int'(ip_hdr[0][3:0]) + int'(UDP_HDR_LEN);
                if (int'(seen_count) < udp_end) begin
                    v.drop  = 1'b1;
                    v.cause = CAUSE_SHORT_UDP;
                end else begin
                    v.source_port = port_cap;
                    if (port_cap >= drop_lo && port_cap <= drop_hi) begin
                        v.drop  = 1'b1;
                        v.cause = CAUSE_PORT_MATCHED;
                    end else begin
                        v.drop  = 1'b0;
                        v.cause = CAUSE_PORT_ALLOWED;
                    end
                end
            end
            verdict_q.push_back(v);
            seen_count = '0;
            seen_etype = '0;
            port_cap   = '0;
        end
    endtask

    // Register write; only called while the block is idle
    task automatic cfg_write(input logic [CFG_A_W-1:0] idx, input logic [PORT_W-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PORT_LOW:  drop_lo = value;
            CFG_PORT_HIGH: drop_hi = value;
            default: ;
        endcase
    endtask

    // Queue one frame: random payload with the header fields laid over it
    task automatic add_frame(input int len, input logic [ETYPE_W-1:0] etype,
                             input logic [IHL_W-1:0] ihl, input logic [BYTE_W-1:0] proto,
                             input logic [PORT_W-1:0] port);
        logic [BYTE_W-1:0] fb[$];
        int                start;
        t_frame_xfer       x;
        for (int i = 0; i < len; i++)
            fb.push_back(BYTE_W'($urandom_range(0, 255)));
        start = int'(ETH_HDR_LEN) + 4 * int'(ihl);
        // port first: with a small ihl the header fields win where they overlap
        if (start < len)
            fb[start] = port[15:8];
        if (start + 1 < len)
            fb[start + 1] = port[7:0];
        if (int'(ETYPE_HI_POS) < len)
            fb[ETYPE_HI_POS] = etype[15:8];
        if (int'(ETYPE_LO_POS) < len)
            fb[ETYPE_LO_POS] = etype[7:0];
        if (int'(ETH_HDR_LEN) < len)
            fb[ETH_HDR_LEN][3:0] = ihl;
        if (int'(PROTO_POS) < len)
            fb[PROTO_POS] = proto;
        for (int i = 0; i < len; i++) begin
            x.data = fb[i];
            x.last = (i == len - 1);
            frame_byte_q.push_back(x);
        end
        phase_bytes  += len;
        phase_frames += 1;
    endtask

    function automatic logic [PORT_W-1:0] pick_port();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pick_port = (drop_lo <= drop_hi) ?
                                    PORT_W'($urandom_range(drop_lo, drop_hi)) :
                                    PORT_W'($urandom_range(0, 65535));
            4:          pick_port = drop_lo;
            5:          pick_port = drop_hi;
            6:          pick_port = drop_lo - 1'b1;
            7:          pick_port = drop_hi + 1'b1;
            default:    pick_port = PORT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [IHL_W-1:0] pick_ihl();
        pick_ihl = ($urandom_range(0, 9) < 7) ? IHL_W'(5) : IHL_W'($urandom_range(0, 15));
    endfunction

    // Mostly well-formed UDP frames; the rest exercises each early exit
    task automatic add_random_frame();
        int                 r;
        int                 len;
        int                 udp_end;
        logic [IHL_W-1:0]   ihl;
        logic [ETYPE_W-1:0] et;
        logic [BYTE_W-1:0]  pr;
        r   = $urandom_range(0, 99);
        ihl = pick_ihl();
        udp_end = int'(ETH_HDR_LEN) + 4 * int'(ihl) + int'(UDP_HDR_LEN);
        if (udp_end < int'(IP_MIN_END))
            udp_end = int'(IP_MIN_END);
        if (r < 5) begin
            add_frame($urandom_range(1, 13), ETHERTYPE_IPV4, ihl, PROTO_UDP, pick_port());
        end else if (r < 12) begin
            et = ETYPE_W'($urandom_range(0, 65535));
            if (et == ETHERTYPE_IPV4)
                et = 16'h86dd;
            add_frame($urandom_range(14, 60), et, ihl, PROTO_UDP, pick_port());
        end else if (r < 18) begin
            add_frame($urandom_range(14, 33), ETHERTYPE_IPV4, ihl, PROTO_UDP, pick_port());
        end else if (r < 26) begin
            pr = BYTE_W'($urandom_range(0, 255));
            if (pr == PROTO_UDP)
                pr = 8'd6;
            add_frame($urandom_range(34, 60), ETHERTYPE_IPV4, ihl, pr, pick_port());
        end else if (r < 34) begin
            len = udp_end - $urandom_range(1, 8);
            if (len < int'(IP_MIN_END))
                len = int'(IP_MIN_END);
            add_frame(len, ETHERTYPE_IPV4, ihl, PROTO_UDP, pick_port());
        end else if (r < 37) begin
            add_frame($urandom_range(125, 170), ETHERTYPE_IPV4, ihl, PROTO_UDP, pick_port());
        end else begin
            len = udp_end + $urandom_range(0, 20);
            add_frame(len, ETHERTYPE_IPV4, ihl, PROTO_UDP, pick_port());
        end
    endtask

    // Hold off until every queued byte went through and every verdict came back
    task automatic wait_drained();
        while (frame_byte_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (VERDICT_LATENCY + 3) @(posedge i_clk);
    endtask

    // Frame byte driver with random idle bursts
    always @(posedge i_clk) begin : frame_driver
        logic        took;
        t_frame_xfer nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap       <= 0;
        end else begin
            took = s_axis_tvalid && s_axis_tready;
            if (took)
                filter_byte(s_axis_tdata, s_axis_tlast);
            if (took || !s_axis_tvalid) begin
                if (src_gap != 0) begin
                    src_gap       <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
                    src_gap       <= $urandom_range(0, 16);
                    s_axis_tvalid <= 1'b0;
                end else if (frame_byte_q.size() != 0) begin
                    nxt = frame_byte_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.data;
                    s_axis_tlast  <= nxt.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Verdict monitor with random stall bursts
    always @(posedge i_clk) begin : verdict_monitor
        t_verdict exp_v;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_gap       <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: verdict with none expected, got tdata %h",
                             $time, m_axis_tdata);
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (m_axis_tdata[0] !== exp_v.drop) begin
                        errors = errors + 1;
                        $display("%0t: drop expected %0d actual %0d",
                                 $time, exp_v.drop, m_axis_tdata[0]);
                    end
                    if (m_axis_tdata[3:1] !== exp_v.cause) begin
                        errors = errors + 1;
                        $display("%0t: cause expected %0d actual %0d",
                                 $time, exp_v.cause, m_axis_tdata[3:1]);
                    end
                    if (m_axis_tdata[19:4] !== exp_v.source_port) begin
                        errors = errors + 1;
                        $display("%0t: source_port expected %0d actual %0d",
                                 $time, exp_v.source_port, m_axis_tdata[19:4]);
                    end
                    if (m_axis_tdata[23:20] !== 4'd0) begin
                        errors = errors + 1;
                        $display("%0t: tdata pad expected 0 actual %h",
                                 $time, m_axis_tdata[23:20]);
                    end
                end
            end
            if (snk_gap != 0) begin
                snk_gap       <= snk_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
                snk_gap       <= $urandom_range(0, 16);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int lo;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at the reset port range
        @(negedge i_clk);
        phase_bytes  = 0;
        phase_frames = 0;
        add_frame(1, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd5350);
        add_frame(13, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd5350);
        add_frame(14, 16'h86dd, 4'd5, PROTO_UDP, 16'd5350);
        add_frame(14, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd5350);
        add_frame(33, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd5350);
        add_frame(34, ETHERTYPE_IPV4, 4'd5, 8'd6, 16'd5350);
        add_frame(41, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd5350);
        add_frame(42, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd5350);
        add_frame(42, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd5357);
        add_frame(42, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd5349);
        add_frame(42, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd5358);
        // port inside the IP header when ihl is small, and at the largest ihl
        add_frame(34, ETHERTYPE_IPV4, 4'd0, PROTO_UDP, 16'h14e6);
        add_frame(34, ETHERTYPE_IPV4, 4'd2, PROTO_UDP, 16'h1411);
        add_frame(34, ETHERTYPE_IPV4, 4'd4, PROTO_UDP, 16'h0000);
        add_frame(82, ETHERTYPE_IPV4, 4'd15, PROTO_UDP, 16'hffff);
        add_frame(81, ETHERTYPE_IPV4, 4'd15, PROTO_UDP, 16'd5352);
        // saturating byte count
        add_frame(127, ETHERTYPE_IPV4, 4'd15, PROTO_UDP, 16'd5353);
        add_frame(128, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd5354);
        add_frame(200, 16'hffff, 4'd5, PROTO_UDP, 16'd5355);
        wait_drained();

        // Random phases, each at its own port range
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    cfg_write(CFG_PORT_LOW, 16'd0);
                    cfg_write(CFG_PORT_HIGH, 16'hffff);
                    cfg_write(CFG_SPARE_2, PORT_W'($urandom_range(0, 65535)));
                end
                1: begin
                    cfg_write(CFG_PORT_LOW, 16'hffff);
                    cfg_write(CFG_PORT_HIGH, 16'd0);
                    cfg_write(CFG_SPARE_3, PORT_W'($urandom_range(0, 65535)));
                end
                2: begin
                    lo = $urandom_range(0, 65535);
                    cfg_write(CFG_PORT_LOW, PORT_W'(lo));
                    lo = lo + $urandom_range(0, 300);
                    cfg_write(CFG_PORT_HIGH, PORT_W'((lo > 65535) ? 65535 : lo));
                end
                3: begin
                    cfg_write(CFG_PORT_LOW, 16'd0);
                    cfg_write(CFG_PORT_HIGH, 16'd0);
                end
                4: begin
                    cfg_write(CFG_PORT_HIGH, 16'hffff);
                    cfg_write(CFG_PORT_LOW, 16'hffff);
                end
                default: begin
                    cfg_write(CFG_PORT_LOW, PORT_W'($urandom_range(0, 65535)));
                    cfg_write(CFG_PORT_HIGH, PORT_W'($urandom_range(0, 65535)));
                end
            endcase
            // one stretch without idling mid-run, and none in the last part
            src_idle_pct = (ph == 2 || ph == NUM_PHASES - 1) ? 0 : $urandom_range(5, 25);
            snk_idle_pct = (ph == 2 || ph == NUM_PHASES - 1) ? 0 : $urandom_range(5, 25);
            @(negedge i_clk);
            phase_bytes  = 0;
            phase_frames = 0;
            while (phase_bytes < 60 || phase_frames < 2)
                add_random_frame();
            wait_drained();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
